// ===== sv/fdt_pkg.sv =====
package fdt_pkg;

  localparam int TEMP_W = 16;
  localparam int DUTY_W = 10;
  localparam int HYST_W = 10;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;
  localparam int SENS_W = 8;
  localparam int REJ_W  = 3;
  localparam int CNT_W  = 32;
  localparam int QUO_W  = 10;
  localparam int NUM_W  = TEMP_W + QUO_W;
  localparam int STEP_W = 4;

  localparam logic [DUTY_W-1:0] DUTY_FULL     = 10'd1000;
  localparam logic [DUTY_W-1:0] DUTY_ON_LEVEL = 10'd5;
  localparam logic [REJ_W-1:0]  FAN_COUNT     = 3'd4;
  localparam logic [STEP_W-1:0] DIV_STEPS     = 4'd10;

  localparam logic [TEMP_W-1:0] RAMP_START_RST  = 16'd640;
  localparam logic [TEMP_W-1:0] FULL_SPEED_RST  = 16'd880;
  localparam logic [HYST_W-1:0] OFF_HYST_RST    = 10'd48;
  localparam logic [DUTY_W-1:0] MIN_DUTY_RST    = 10'd250;
  localparam logic [DUTY_W-1:0] CHARGE_DUTY_RST = 10'd350;

  localparam logic [IDX_W-1:0] REG_RAMP_START  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FULL_SPEED  = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFF_HYST    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_DUTY    = 3'd3;
  localparam logic [IDX_W-1:0] REG_CHARGE_DUTY = 3'd4;

  typedef enum logic [2:0] {
    CAUSE_OFF_COOL,
    CAUSE_INVALID,
    CAUSE_FAULT,
    CAUSE_MAX,
    CAUSE_MIN_HYST,
    CAUSE_CHARGE,
    CAUSE_RAMP,
    CAUSE_DRIVER
  } cause_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] ramp_start;
    logic signed [TEMP_W-1:0] full_speed;
    logic [HYST_W-1:0]        hyst;
    logic [DUTY_W-1:0]        min_duty;
    logic [DUTY_W-1:0]        charge_duty;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/fdt_cfg.sv =====
module fdt_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [fdt_pkg::IDX_W-1:0] wr_index,
  input  logic [fdt_pkg::CFG_W-1:0] wr_data,
  output fdt_pkg::cfg_t             cfg
);

  logic [fdt_pkg::TEMP_W-1:0] ramp_start;
  logic [fdt_pkg::TEMP_W-1:0] full_speed;
  logic [fdt_pkg::HYST_W-1:0] hyst;
  logic [fdt_pkg::DUTY_W-1:0] min_duty;
  logic [fdt_pkg::DUTY_W-1:0] charge_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_start  <= fdt_pkg::RAMP_START_RST;
      full_speed  <= fdt_pkg::FULL_SPEED_RST;
      hyst        <= fdt_pkg::OFF_HYST_RST;
      min_duty    <= fdt_pkg::MIN_DUTY_RST;
      charge_duty <= fdt_pkg::CHARGE_DUTY_RST;
    end else if (wr_en) begin
      case (wr_index)
        fdt_pkg::REG_RAMP_START:  ramp_start  <= wr_data;
        fdt_pkg::REG_FULL_SPEED:  full_speed  <= wr_data;
        fdt_pkg::REG_OFF_HYST:    hyst        <= wr_data[fdt_pkg::HYST_W-1:0];
        fdt_pkg::REG_MIN_DUTY:    min_duty    <= wr_data[fdt_pkg::DUTY_W-1:0];
        fdt_pkg::REG_CHARGE_DUTY: charge_duty <= wr_data[fdt_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // duty settings above full scale act as full scale
  always_comb begin
    cfg.ramp_start  = ramp_start;
    cfg.full_speed  = full_speed;
    cfg.hyst        = hyst;
    cfg.min_duty    = (min_duty > fdt_pkg::DUTY_FULL) ? fdt_pkg::DUTY_FULL : min_duty;
    cfg.charge_duty = (charge_duty > fdt_pkg::DUTY_FULL) ? fdt_pkg::DUTY_FULL : charge_duty;
  end

endmodule

// ===== sv/fdt_div.sv =====
module fdt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fdt_pkg::NUM_W-1:0]   num,
  input  logic [fdt_pkg::TEMP_W-1:0]  den,
  output logic [fdt_pkg::QUO_W-1:0]   quo,
  output fdt_pkg::div_stat_t          stat
);

  logic [fdt_pkg::TEMP_W-1:0] rem;
  logic [fdt_pkg::QUO_W-1:0]  sh;
  logic [fdt_pkg::STEP_W-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [fdt_pkg::TEMP_W:0]   trial;
  logic [fdt_pkg::TEMP_W:0]   diff;
  logic                       ge;

  // restoring division, one quotient bit per cycle; the caller keeps
  // num below den * 2^QUO_W so the top slice already sits under den
  assign trial = {rem, sh[fdt_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= fdt_pkg::DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[fdt_pkg::NUM_W-1:fdt_pkg::QUO_W];
      sh  <= num[fdt_pkg::QUO_W-1:0];
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? diff[fdt_pkg::TEMP_W-1:0] : trial[fdt_pkg::TEMP_W-1:0];
      sh  <= {sh[fdt_pkg::QUO_W-2:0], 1'b0};
      quo <= {quo[fdt_pkg::QUO_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("divider busy with no steps left");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a run");

  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    done |-> quo < fdt_pkg::DUTY_FULL)
    else $error("ramp quotient out of range");

endmodule

// ===== sv/fan_duty_from_temperature.sv =====
// Fan duty from temperature, one item at a time; output stalls add their length.
// Result registered through the calc and load states, or calc, divide and load
// when the ramp is taken (the serial divider yields one quotient bit per cycle).
// A new beat is taken only once the last result is loaded and the block is idle.
// Synchronous reset restores register defaults and clears duty history,
// cause and the failure count; no clearing pass.
module fan_duty_from_temperature (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fdt_pkg::TEMP_W-1:0] peak_temp,
  input  logic                              reading_ok,
  input  logic                              sensor_fault,
  input  logic [fdt_pkg::SENS_W-1:0]        usable_sensors,
  input  logic                              over_temp_fault,
  input  logic                              force_full_flag,
  input  logic                              charging,
  input  logic [fdt_pkg::REJ_W-1:0]         fans_rejected,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fdt_pkg::DUTY_W-1:0]        duty,
  output logic                              fan_on,
  output logic [2:0]                        cause,
  output logic                              prior_driver_fault,
  output logic [fdt_pkg::CNT_W-1:0]         fail_total,
  input  logic                              wr_en,
  input  logic [fdt_pkg::IDX_W-1:0]         wr_index,
  input  logic [fdt_pkg::CFG_W-1:0]         wr_data
);

  fdt_pkg::cfg_t      cfg;
  fdt_pkg::div_stat_t div_stat;
  fdt_pkg::state_t    state, state_next;

  logic signed [fdt_pkg::TEMP_W-1:0] t_r;
  logic                              bad_r, ot_r, force_r, chg_r;
  logic [fdt_pkg::REJ_W-1:0]         rej_r;

  logic [fdt_pkg::DUTY_W-1:0] last_duty;
  fdt_pkg::cause_t            last_cause;
  logic [fdt_pkg::CNT_W-1:0]  fail_counter;

  logic [fdt_pkg::DUTY_W-1:0] res_duty;
  fdt_pkg::cause_t            res_cause;
  logic                       res_ramp;
  logic                       rej_flag;

  logic div_start, load_out, accept;

  logic signed [fdt_pkg::TEMP_W:0]   t_x, rs_x, fs_x, span, delta;
  logic signed [fdt_pkg::TEMP_W+1:0] t_b, band_low;
  logic [fdt_pkg::NUM_W-1:0]         num;
  logic [fdt_pkg::QUO_W-1:0]         quo;
  logic [fdt_pkg::CNT_W:0]           fail_sum;
  fdt_pkg::cause_t                   cause_eff, dec_cause, fin_cause, cause_q;
  logic [fdt_pkg::DUTY_W-1:0]        dec_duty, fin_duty, ramp_duty;
  logic                              dec_ramp, was_on, span_pos;

  fdt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  fdt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (span[fdt_pkg::TEMP_W-1:0]),
    .quo   (quo),
    .stat  (div_stat)
  );

  assign accept = in_valid && !in_stall;

  // classification, evaluated in the calc state
  assign t_x      = {t_r[fdt_pkg::TEMP_W-1], t_r};
  assign rs_x     = {cfg.ramp_start[fdt_pkg::TEMP_W-1], cfg.ramp_start};
  assign fs_x     = {cfg.full_speed[fdt_pkg::TEMP_W-1], cfg.full_speed};
  assign span     = fs_x - rs_x;
  assign span_pos = !span[fdt_pkg::TEMP_W] && (span != '0);
  assign delta    = t_x - rs_x;
  assign num      = fdt_pkg::NUM_W'(delta[fdt_pkg::TEMP_W-1:0])
                    * fdt_pkg::NUM_W'(fdt_pkg::DUTY_FULL);
  assign t_b      = {t_x[fdt_pkg::TEMP_W], t_x};
  assign band_low = {rs_x[fdt_pkg::TEMP_W], rs_x} - {8'd0, cfg.hyst};

  // a rejection of the previous command counts as a driver fault
  assign cause_eff = (rej_r != '0) ? fdt_pkg::CAUSE_DRIVER : last_cause;
  assign was_on    = (last_duty > fdt_pkg::DUTY_ON_LEVEL) &&
                     (cause_eff != fdt_pkg::CAUSE_MAX) &&
                     (cause_eff != fdt_pkg::CAUSE_INVALID) &&
                     (cause_eff != fdt_pkg::CAUSE_FAULT) &&
                     (cause_eff != fdt_pkg::CAUSE_DRIVER);
  assign fail_sum  = {1'b0, fail_counter} + (fdt_pkg::CNT_W+1)'(rej_r);

  always_comb begin
    dec_duty  = '0;
    dec_cause = fdt_pkg::CAUSE_OFF_COOL;
    dec_ramp  = 1'b0;
    if (bad_r) begin
      dec_duty  = fdt_pkg::DUTY_FULL;
      dec_cause = fdt_pkg::CAUSE_INVALID;
    end else if (ot_r) begin
      dec_duty  = fdt_pkg::DUTY_FULL;
      dec_cause = fdt_pkg::CAUSE_FAULT;
    end else if (force_r || (t_x >= fs_x) || !span_pos) begin
      dec_duty  = fdt_pkg::DUTY_FULL;
      dec_cause = fdt_pkg::CAUSE_MAX;
    end else if (t_b <= band_low) begin
      dec_cause = fdt_pkg::CAUSE_OFF_COOL;
    end else if (t_x <= rs_x) begin
      if (was_on) begin
        dec_duty  = cfg.min_duty;
        dec_cause = fdt_pkg::CAUSE_MIN_HYST;
      end else if (chg_r) begin
        dec_duty  = cfg.charge_duty;
        dec_cause = fdt_pkg::CAUSE_CHARGE;
      end
    end else begin
      dec_ramp  = 1'b1;
      dec_cause = fdt_pkg::CAUSE_RAMP;
    end
  end

  // ramp floors
  assign ramp_duty = (quo < cfg.min_duty) ? cfg.min_duty : quo;

  always_comb begin
    fin_duty  = res_duty;
    fin_cause = res_cause;
    if (res_ramp) begin
      if (chg_r && (ramp_duty < cfg.charge_duty)) begin
        fin_duty  = cfg.charge_duty;
        fin_cause = fdt_pkg::CAUSE_CHARGE;
      end else begin
        fin_duty  = ramp_duty;
        fin_cause = fdt_pkg::CAUSE_RAMP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      fdt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = fdt_pkg::ST_CALC;
      end
      fdt_pkg::ST_CALC: begin
        if (dec_ramp) begin
          div_start  = 1'b1;
          state_next = fdt_pkg::ST_DIV;
        end else begin
          state_next = fdt_pkg::ST_LOAD;
        end
      end
      fdt_pkg::ST_DIV: begin
        if (div_stat.done) state_next = fdt_pkg::ST_LOAD;
      end
      fdt_pkg::ST_LOAD: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = fdt_pkg::ST_IDLE;
        end
      end
      default: state_next = fdt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      last_duty    <= '0;
      last_cause   <= fdt_pkg::CAUSE_OFF_COOL;
      fail_counter <= '0;
    end else begin
      out_valid <= load_out || (out_valid && out_stall);
      if (state == fdt_pkg::ST_CALC) begin
        fail_counter <= fail_sum[fdt_pkg::CNT_W] ? '1 : fail_sum[fdt_pkg::CNT_W-1:0];
      end
      if (load_out) begin
        last_duty  <= fin_duty;
        last_cause <= fin_cause;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t_r     <= peak_temp;
      bad_r   <= !reading_ok || sensor_fault || (usable_sensors == '0);
      ot_r    <= over_temp_fault;
      force_r <= force_full_flag;
      chg_r   <= charging;
      rej_r   <= (fans_rejected > fdt_pkg::FAN_COUNT) ? fdt_pkg::FAN_COUNT : fans_rejected;
    end
    if (state == fdt_pkg::ST_CALC) begin
      res_duty  <= dec_duty;
      res_cause <= dec_cause;
      res_ramp  <= dec_ramp;
      rej_flag  <= rej_r != '0;
    end
    if (load_out) begin
      duty               <= fin_duty;
      fan_on             <= fin_duty > fdt_pkg::DUTY_ON_LEVEL;
      cause_q            <= fin_cause;
      prior_driver_fault <= rej_flag;
      fail_total         <= fail_counter;
    end
  end

  assign cause = cause_q;

  a_fail_monotone: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> fail_counter >= $past(fail_counter))
    else $error("failure count went down");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty <= fdt_pkg::DUTY_FULL && fan_on == (duty > fdt_pkg::DUTY_ON_LEVEL))
    else $error("duty out of range or fan_on inconsistent");

  // a minimum duty at full scale lifts the ramp to full scale
  a_ramp_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && cause_q == fdt_pkg::CAUSE_RAMP |->
      duty >= cfg.min_duty && duty <= fdt_pkg::DUTY_FULL)
    else $error("ramp duty outside its floor and ceiling");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule
